// ===== hdl/manhattan_order_cell_generator_assert.svh =====
// Assertion macros for the Manhattan-order cell generator.
// Every macro samples on the rising edge of clk and is switched off during reset.
`ifndef MANHATTAN_ORDER_CELL_GENERATOR_ASSERT_SVH
`define MANHATTAN_ORDER_CELL_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define MOCG_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: invariant");
`define MOCG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define MOCG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define MOCG_ASSERT_ALWAYS(lbl, expr)
`define MOCG_ASSERT_IMP(lbl, ante, cons)
`define MOCG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/mocg_pkg.sv =====
package mocg_pkg;

  // Fixed port widths.
  localparam int ROW_W     = 7;
  localparam int COL_W     = 7;
  localparam int DIST_W    = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CTR_W     = 7;  // width of the centre registers

  // Register indices.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL = 2'd3;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch the request word
    logic emit;     // produce the cell and take the first step of the advance
    logic step;     // scan one candidate row
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_blocked;  // output register still holds an untaken word
    logic emit_finish;  // next position already known after the emit
    logic step_finish;  // scan has landed on the next cell
  } sts_t;

endpackage

// ===== hdl/mocg_ctrl.sv =====
module mocg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mocg_pkg::sts_t sts,
  output mocg_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_SEARCH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EMIT;
        end
        S_EMIT: begin
          if (!sts.out_blocked) state <= sts.emit_finish ? S_IDLE : S_SEARCH;
        end
        S_SEARCH: begin
          if (sts.step_finish) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.emit    = (state == S_EMIT) && !sts.out_blocked;
    cmd.step    = (state == S_SEARCH);
  end

endmodule

// ===== hdl/mocg_datapath.sv =====
module mocg_datapath #(
  parameter int MAX_DIM = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mocg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mocg_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               restart,
  input  mocg_pkg::cmd_t                     cmd,
  output mocg_pkg::sts_t                     sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mocg_pkg::ROW_W-1:0]         cell_row,
  output logic [mocg_pkg::COL_W-1:0]         cell_col,
  output logic [mocg_pkg::DIST_W-1:0]        cell_distance,
  output logic                               last_cell
);

  // Grid sizes are 8-bit registers, so the usable size also stops at 255.
  localparam int EFF_MAX = (MAX_DIM < 255) ? MAX_DIM : 255;
  localparam int IDX_W   = $clog2(EFF_MAX);
  localparam int SIZE_W  = $clog2(EFF_MAX + 1);
  localparam int D_W     = $clog2(2 * EFF_MAX - 1);
  localparam int CNT_W   = $clog2(EFF_MAX * EFF_MAX + 1);
  localparam int AW      = D_W + 2;
  localparam logic [mocg_pkg::CFG_W-1:0] EFF_MAX_C = mocg_pkg::CFG_W'(EFF_MAX);
  localparam logic [D_W-1:0]             D_MAX     = D_W'(2 * EFF_MAX - 2);

  // Configuration registers
  logic [mocg_pkg::CFG_W-1:0] grid_rows, grid_cols;
  logic [mocg_pkg::CTR_W-1:0] center_row, center_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows  <= mocg_pkg::CFG_W'(1);
      grid_cols  <= mocg_pkg::CFG_W'(1);
      center_row <= '0;
      center_col <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mocg_pkg::REG_GRID_ROWS:  grid_rows  <= cfg_data;
        mocg_pkg::REG_GRID_COLS:  grid_cols  <= cfg_data;
        mocg_pkg::REG_CENTER_ROW: center_row <= cfg_data[mocg_pkg::CTR_W-1:0];
        mocg_pkg::REG_CENTER_COL: center_col <= cfg_data[mocg_pkg::CTR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry
  logic [mocg_pkg::CFG_W-1:0] rows_sat, cols_sat;
  logic [SIZE_W-1:0]          eff_rows, eff_cols;
  logic [IDX_W-1:0]           eff_cr, eff_cc;

  always_comb begin
    rows_sat = (grid_rows == '0) ? mocg_pkg::CFG_W'(1) :
               ((grid_rows > EFF_MAX_C) ? EFF_MAX_C : grid_rows);
    cols_sat = (grid_cols == '0) ? mocg_pkg::CFG_W'(1) :
               ((grid_cols > EFF_MAX_C) ? EFF_MAX_C : grid_cols);
    eff_rows = SIZE_W'(rows_sat);
    eff_cols = SIZE_W'(cols_sat);
    eff_cr = ({1'b0, center_row} < rows_sat) ? IDX_W'(center_row) :
             IDX_W'(rows_sat - mocg_pkg::CFG_W'(1));
    eff_cc = ({1'b0, center_col} < cols_sat) ? IDX_W'(center_col) :
             IDX_W'(cols_sat - mocg_pkg::CFG_W'(1));
  end

  // Registered cell count; configuration moves in idle only by user rule
  logic [CNT_W-1:0] total;

  always_ff @(posedge clk) begin
    total <= CNT_W'(CNT_W'(eff_rows) * CNT_W'(eff_cols));
  end

  // Walk position
  logic [D_W-1:0]    cur_dist;
  logic [SIZE_W-1:0] row;
  logic              side;
  logic [CNT_W-1:0]  cnt;
  logic              restart_q;

  // Probe of the stored position: both cells of (cur_dist, row)
  logic [AW-1:0]    a_r, a_cr, a_d, a_cc, a_rows, a_cols, dr, k;
  logic             in_rng, ok_l, ok_r, exhausted;
  logic [IDX_W-1:0] col_l, col_r;

  always_comb begin
    a_r    = AW'(row);
    a_cr   = AW'(eff_cr);
    a_d    = AW'(cur_dist);
    a_cc   = AW'(eff_cc);
    a_rows = AW'(eff_rows);
    a_cols = AW'(eff_cols);
    dr     = (a_r >= a_cr) ? (a_r - a_cr) : (a_cr - a_r);
    in_rng = (a_r < a_rows) && (dr <= a_d);
    k      = a_d - dr;
    ok_l   = in_rng && (k <= a_cc);
    ok_r   = in_rng && (k != '0) && ((a_cc + k) < a_cols);
    col_l  = IDX_W'(a_cc - k);
    col_r  = IDX_W'(a_cc + k);
    exhausted = (a_r >= a_rows) || (a_r > (a_cr + a_d));
  end

  // Emit-cycle values
  logic              start;
  logic [SIZE_W-1:0] e_row;
  logic [IDX_W-1:0]  e_col;
  logic [D_W-1:0]    e_dist;
  logic [CNT_W-1:0]  e_cnt_inc;
  logic              e_last, right_next;
  logic [AW-1:0]     d_inc;
  logic [SIZE_W-1:0] wrap_row;

  always_comb begin
    start = restart_q || (cnt >= total) || !(side ? ok_r : ok_l);
    e_row     = start ? SIZE_W'(eff_cr) : row;
    e_col     = start ? eff_cc : (side ? col_r : col_l);
    e_dist    = start ? '0 : cur_dist;
    e_cnt_inc = (start ? '0 : cnt) + CNT_W'(1);
    e_last    = (e_cnt_inc == total);
    right_next = !start && !side && ok_r;
    // first row of the next distance band
    d_inc    = a_d + AW'(1);
    wrap_row = (a_cr > d_inc) ? SIZE_W'(a_cr - d_inc) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_dist  <= '0;
      row       <= '0;
      side      <= 1'b0;
      cnt       <= '0;
      restart_q <= 1'b0;
    end else begin
      if (cmd.capture) restart_q <= restart;
      if (cmd.emit) begin
        if (e_last) begin
          cur_dist <= '0;
          row      <= SIZE_W'(eff_cr);
          side     <= 1'b0;
          cnt      <= '0;
        end else begin
          cnt <= e_cnt_inc;
          if (right_next) begin
            side <= 1'b1;
          end else begin
            cur_dist <= e_dist;
            row      <= e_row + SIZE_W'(1);
          end
        end
      end else if (cmd.step) begin
        priority if (exhausted) begin
          if (cur_dist == D_MAX) begin
            // no cell left; cannot happen while the count is consistent
            cur_dist <= '0;
            row      <= SIZE_W'(eff_cr);
            side     <= 1'b0;
            cnt      <= '0;
          end else begin
            cur_dist <= cur_dist + D_W'(1);
            row      <= wrap_row;
          end
        end else if (ok_l) begin
          side <= 1'b0;
        end else if (ok_r) begin
          side <= 1'b1;
        end else begin
          row <= row + SIZE_W'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cell_row      <= mocg_pkg::ROW_W'(e_row);
      cell_col      <= mocg_pkg::COL_W'(e_col);
      cell_distance <= mocg_pkg::DIST_W'(e_dist);
      last_cell     <= e_last;
    end
  end

  always_comb begin
    sts.out_blocked = out_valid && !out_ready;
    sts.emit_finish = e_last || right_next;
    sts.step_finish = (exhausted && (cur_dist == D_MAX)) ||
                      (!exhausted && (ok_l || ok_r));
  end

endmodule

// ===== hdl/manhattan_order_cell_generator.sv =====
// Manhattan-order cell generator. Each request word returns one grid cell, walking outward
// from the configured centre in rings of rising Manhattan distance; within a ring rows come
// in ascending order and, within a row, the left cell before the right. The word after the
// last cell (last_cell high) starts again at the centre, and restart high begins a fresh walk
// at the centre before the cell is produced. Grid sizes of 0 read as 1, sizes above MAX_DIM
// saturate, and a centre outside the grid is clamped to the last row or column. Write the
// four registers only while the block is idle; the cell count is re-derived in a register
// behind the size registers. Flow: a request is taken in idle, the cell is loaded into the
// output register in the emit state (held off while the previous word is still untaken), and
// the position of the following cell is then found by a row scanner that tests one candidate
// row per cycle. A second cell in the same row needs no scan, the next row is found by a scan
// of that row, and a step to the next ring first moves the scanner to that ring's first row
// and then past each candidate row that holds no cell of that ring. The scan over empty rows
// sets the worst case. Requests are taken only while the scanner is idle; a finished word
// may wait in the output register meanwhile.
`include "manhattan_order_cell_generator_assert.svh"

module manhattan_order_cell_generator #(
  parameter int MAX_DIM = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [mocg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mocg_pkg::CFG_W-1:0]     cfg_data,
  // request word
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           restart,
  // result word
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mocg_pkg::ROW_W-1:0]     cell_row,
  output logic [mocg_pkg::COL_W-1:0]     cell_col,
  output logic [mocg_pkg::DIST_W-1:0]    cell_distance,
  output logic                           last_cell
);

  mocg_pkg::cmd_t cmd;
  mocg_pkg::sts_t sts;

  // sequencer: idle / emit / scan
  mocg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // registers, walk position, row probe and output register
  mocg_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .restart       (restart),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cell_row      (cell_row),
    .cell_col      (cell_col),
    .cell_distance (cell_distance),
    .last_cell     (last_cell)
  );

  // A taken request leaves idle, so no second word slips in before the emit.
  `MOCG_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, !in_ready)
  // The output register is only loaded when it is free or being emptied.
  `MOCG_ASSERT_IMP(a_no_overwrite, cmd.emit, !out_valid || out_ready)
  // Capture, emit and scan never overlap.
  `MOCG_ASSERT_ALWAYS(a_cmd_exclusive, $onehot0({cmd.capture, cmd.emit, cmd.step}))
  // Every emit shows up as a valid word on the next cycle.
  `MOCG_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid)

endmodule
